// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared constants and types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned COLOR_BITS_DEF    = 8;
  localparam int unsigned HUE_FRAC_BITS_DEF = 8;

  // Integer bits of the hue: it spans 0 to 6 inclusive
  localparam int unsigned HUE_INT_BITS = 3;
  localparam int unsigned HUE_SECTORS  = 6;

  // Hue sector, chosen by which component is the minimum
  typedef enum logic [1:0] {
    SEC_RED_MIN   = 2'd0,
    SEC_GREEN_MIN = 2'd1,
    SEC_BLUE_MIN  = 2'd2
  } sector_e;

  // Forward control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic undef;
  } rhc_ctrl_t;

endpackage

// ===== rtl/rhc_pix_if.sv =====
// ----------------------------------------------------------------------------
// rhc_pix_if
// Pixel channel: one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface rhc_pix_if #(
  parameter int unsigned COLOR_BITS = rhc_pkg::COLOR_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/rhc_hsv_if.sv =====
// ----------------------------------------------------------------------------
// rhc_hsv_if
// HSV channel: one converted pixel per transaction.
// ----------------------------------------------------------------------------
interface rhc_hsv_if #(
  parameter int unsigned COLOR_BITS    = rhc_pkg::COLOR_BITS_DEF,
  parameter int unsigned HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
);
  localparam int unsigned HueW = HUE_FRAC_BITS + rhc_pkg::HUE_INT_BITS;

  logic                  valid;
  logic                  ready;
  logic [HueW-1:0]       hue;
  logic [COLOR_BITS-1:0] saturation;
  logic [COLOR_BITS-1:0] brightness;
  logic                  hue_undefined;

  modport source (output valid, output hue, output saturation, output brightness,
                  output hue_undefined, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input hue_undefined, output ready);
endinterface

// ===== rtl/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front
// Two front stages: max/min and sector pick, then range, hue numerator
// and saturation dividend.
// ----------------------------------------------------------------------------
module rhc_front #(
  parameter int unsigned COLOR_BITS = rhc_pkg::COLOR_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [COLOR_BITS-1:0]     red_i,
  input  logic [COLOR_BITS-1:0]     green_i,
  input  logic [COLOR_BITS-1:0]     blue_i,
  output rhc_pkg::rhc_ctrl_t        ctrl_o,
  input  logic                      ready_i,
  output logic [COLOR_BITS-1:0]     hi_o,
  output logic [COLOR_BITS-1:0]     d_o,
  output logic [COLOR_BITS+2:0]     num_o,
  output logic [2*COLOR_BITS-1:0]   y_o
);
  import rhc_pkg::*;

  localparam int unsigned CB = COLOR_BITS;

  // stage A
  logic              a_vld_q;
  logic [CB-1:0]     a_hi_q, a_hi_d, a_lo_q, a_lo_d;
  sector_e           a_sec_q, a_sec_d;
  logic signed [CB:0] a_diff_q, a_diff_d;
  logic              a_ready;

  // stage B
  logic              b_vld_q, b_undef_q;
  logic [CB-1:0]     b_hi_q, b_d_q, b_d_d;
  logic [CB+2:0]     b_num_q, b_num_d, b_bd;
  logic [2*CB-1:0]   b_y_q, b_y_d;
  logic signed [CB+3:0] b_num_s;

  always_comb begin
    a_hi_d = (red_i > green_i) ? red_i : green_i;
    if (blue_i > a_hi_d) a_hi_d = blue_i;
    a_lo_d = (red_i < green_i) ? red_i : green_i;
    if (blue_i < a_lo_d) a_lo_d = blue_i;

    if (red_i == a_lo_d) begin
      a_sec_d  = SEC_RED_MIN;
      a_diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == a_lo_d) begin
      a_sec_d  = SEC_GREEN_MIN;
      a_diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      a_sec_d  = SEC_BLUE_MIN;
      a_diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  assign ready_o = !a_vld_q || a_ready;
  assign a_ready = !b_vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (ready_o) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_hi_q   <= a_hi_d;
      a_lo_q   <= a_lo_d;
      a_sec_q  <= a_sec_d;
      a_diff_q <= a_diff_d;
    end
  end

  // base * d with base 3, 5 or 1 by shift and add
  always_comb begin
    b_d_d = a_hi_q - a_lo_q;
    case (a_sec_q)
      SEC_RED_MIN:   b_bd = ({3'b000, b_d_d} << 1) + {3'b000, b_d_d};
      SEC_GREEN_MIN: b_bd = ({3'b000, b_d_d} << 2) + {3'b000, b_d_d};
      SEC_BLUE_MIN:  b_bd = {3'b000, b_d_d};
      default:       b_bd = {3'b000, b_d_d};
    endcase
    b_num_s = $signed({1'b0, b_bd}) - $signed({{3{a_diff_q[CB]}}, a_diff_q});
    b_num_d = b_num_s[CB+2:0];
    // d * (2^CB - 1)
    b_y_d   = {b_d_d, {CB{1'b0}}} - {{CB{1'b0}}, b_d_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (a_ready) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && a_vld_q) begin
      b_undef_q <= (a_hi_q == a_lo_q);
      b_hi_q    <= a_hi_q;
      b_d_q     <= b_d_d;
      b_num_q   <= b_num_d;
      b_y_q     <= b_y_d;
    end
  end

  assign ctrl_o.valid = b_vld_q;
  assign ctrl_o.undef = b_undef_q;
  assign hi_o         = b_hi_q;
  assign d_o          = b_d_q;
  assign num_o        = b_num_q;
  assign y_o          = b_y_q;

endmodule

// ===== rtl/rhc_div_stage.sv =====
// ----------------------------------------------------------------------------
// rhc_div_stage
// One stage of the two restoring dividers: at most one hue quotient bit and
// at most one saturation quotient bit, found by compare and subtract of the
// shifted divisor.
// ----------------------------------------------------------------------------
module rhc_div_stage #(
  parameter int unsigned COLOR_BITS    = rhc_pkg::COLOR_BITS_DEF,
  parameter int unsigned HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int unsigned STAGE         = 0
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  rhc_pkg::rhc_ctrl_t                             ctrl_i,
  output logic                                           ready_o,
  input  logic [COLOR_BITS-1:0]                          hi_i,
  input  logic [COLOR_BITS-1:0]                          d_i,
  input  logic [COLOR_BITS+HUE_FRAC_BITS+2:0]            hr_i,
  input  logic [HUE_FRAC_BITS+rhc_pkg::HUE_INT_BITS-1:0] hq_i,
  input  logic [2*COLOR_BITS-1:0]                        sr_i,
  input  logic [COLOR_BITS-1:0]                          sq_i,
  output rhc_pkg::rhc_ctrl_t                             ctrl_o,
  input  logic                                           ready_i,
  output logic [COLOR_BITS-1:0]                          hi_o,
  output logic [COLOR_BITS-1:0]                          d_o,
  output logic [COLOR_BITS+HUE_FRAC_BITS+2:0]            hr_o,
  output logic [HUE_FRAC_BITS+rhc_pkg::HUE_INT_BITS-1:0] hq_o,
  output logic [2*COLOR_BITS-1:0]                        sr_o,
  output logic [COLOR_BITS-1:0]                          sq_o
);
  import rhc_pkg::*;

  localparam int unsigned CB = COLOR_BITS;
  localparam int unsigned QW = HUE_FRAC_BITS + HUE_INT_BITS;
  localparam int unsigned RW = COLOR_BITS + HUE_FRAC_BITS + HUE_INT_BITS;
  localparam int unsigned SW = 2 * COLOR_BITS;
  localparam int unsigned NS = (QW > CB) ? QW : CB;
  // bit weight handled here; the first stage takes the top bit
  localparam int unsigned BIT = NS - 1 - STAGE;

  rhc_ctrl_t       ctrl_q;
  logic [CB-1:0]   hi_q, d_q;
  logic [RW-1:0]   hr_q, hr_d;
  logic [QW-1:0]   hq_q, hq_d;
  logic [SW-1:0]   sr_q, sr_d;
  logic [CB-1:0]   sq_q, sq_d;

  generate
    if (BIT < QW) begin : g_hue
      logic [RW-1:0] dsh;
      logic          ge;
      always_comb begin
        dsh  = {{(RW-CB){1'b0}}, d_i} << BIT;
        ge   = (hr_i >= dsh);
        hr_d = ge ? (hr_i - dsh) : hr_i;
        hq_d = hq_i;
        hq_d[BIT] = ge;
      end
    end else begin : g_hue_idle
      assign hr_d = hr_i;
      assign hq_d = hq_i;
    end

    if (BIT < CB) begin : g_sat
      logic [SW-1:0] hsh;
      logic          ge;
      always_comb begin
        hsh  = {{(SW-CB){1'b0}}, hi_i} << BIT;
        ge   = (sr_i >= hsh);
        sr_d = ge ? (sr_i - hsh) : sr_i;
        sq_d = sq_i;
        sq_d[BIT] = ge;
      end
    end else begin : g_sat_idle
      assign sr_d = sr_i;
      assign sq_d = sq_i;
    end
  endgenerate

  assign ready_o = !ctrl_q.valid || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (ready_o) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctrl_i.valid) begin
      hi_q <= hi_i;
      d_q  <= d_i;
      hr_q <= hr_d;
      hq_q <= hq_d;
      sr_q <= sr_d;
      sq_q <= sq_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign hi_o   = hi_q;
  assign d_o    = d_q;
  assign hr_o   = hr_q;
  assign hq_o   = hq_q;
  assign sr_o   = sr_q;
  assign sq_o   = sq_q;

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGB to HSV pixel converter, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one HSV pixel per clock while the
// output is not stalled. Between accepted pixel and presented result, two
// front stages find max, min and the sector, then one stage per bit of the
// wider quotient serves the restoring hue and saturation dividers together,
// then the output register. The hue is fixed point on [0,6] with HUE_FRAC_BITS
// fraction bits, truncated; hue and saturation are 0 and hue_undefined is set
// when all components are equal. Stalls are taken stage by stage, so empty
// stages still fill while a result waits at the output.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
  parameter int unsigned COLOR_BITS    = rhc_pkg::COLOR_BITS_DEF,
  parameter int unsigned HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhc_pix_if.sink   pixel_i,
  rhc_hsv_if.source hsv_o
);
  import rhc_pkg::*;

  localparam int unsigned CB  = COLOR_BITS;
  localparam int unsigned QW  = HUE_FRAC_BITS + HUE_INT_BITS;
  localparam int unsigned RW  = COLOR_BITS + HUE_FRAC_BITS + HUE_INT_BITS;
  localparam int unsigned SW  = 2 * COLOR_BITS;
  localparam int unsigned NS  = (QW > CB) ? QW : CB;
  localparam logic [QW-1:0] HueMax = QW'(HUE_SECTORS << HUE_FRAC_BITS);

  rhc_ctrl_t      ctrl [NS+1];
  logic           rdy  [NS+1];
  logic [CB-1:0]  hi   [NS+1];
  logic [CB-1:0]  dd   [NS+1];
  logic [RW-1:0]  hr   [NS+1];
  logic [QW-1:0]  hq   [NS+1];
  logic [SW-1:0]  sr   [NS+1];
  logic [CB-1:0]  sq   [NS+1];
  logic [CB+2:0]  num;

  rhc_front #(
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pixel_i.valid),
    .ready_o (pixel_i.ready),
    .red_i   (pixel_i.red),
    .green_i (pixel_i.green),
    .blue_i  (pixel_i.blue),
    .ctrl_o  (ctrl[0]),
    .ready_i (rdy[0]),
    .hi_o    (hi[0]),
    .d_o     (dd[0]),
    .num_o   (num),
    .y_o     (sr[0])
  );

  // hue dividend is the numerator scaled by the fraction bits
  assign hr[0] = {num, {HUE_FRAC_BITS{1'b0}}};
  assign hq[0] = '0;
  assign sq[0] = '0;

  generate
    for (genvar k = 0; k < NS; k++) begin : g_div
      rhc_div_stage #(
        .COLOR_BITS    (COLOR_BITS),
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .STAGE         (k)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl[k]),
        .ready_o (rdy[k]),
        .hi_i    (hi[k]),
        .d_i     (dd[k]),
        .hr_i    (hr[k]),
        .hq_i    (hq[k]),
        .sr_i    (sr[k]),
        .sq_i    (sq[k]),
        .ctrl_o  (ctrl[k+1]),
        .ready_i (rdy[k+1]),
        .hi_o    (hi[k+1]),
        .d_o     (dd[k+1]),
        .hr_o    (hr[k+1]),
        .hq_o    (hq[k+1]),
        .sr_o    (sr[k+1]),
        .sq_o    (sq[k+1])
      );
    end
  endgenerate

  // output register
  logic          out_vld_q;
  logic [QW-1:0] hue_q;
  logic [CB-1:0] sat_q, bri_q;
  logic          undef_q;

  assign rdy[NS] = !out_vld_q || hsv_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy[NS]) begin
      out_vld_q <= ctrl[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS] && ctrl[NS].valid) begin
      hue_q   <= ctrl[NS].undef ? '0 : hq[NS];
      sat_q   <= ctrl[NS].undef ? '0 : sq[NS];
      bri_q   <= hi[NS];
      undef_q <= ctrl[NS].undef;
    end
  end

  assign hsv_o.valid         = out_vld_q;
  assign hsv_o.hue           = hue_q;
  assign hsv_o.saturation    = sat_q;
  assign hsv_o.brightness    = bri_q;
  assign hsv_o.hue_undefined = undef_q;

  // grey pixels carry no hue or saturation
  a_undef_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.hue_undefined |-> hsv_o.hue == '0 && hsv_o.saturation == '0)
    else $error("undefined hue with nonzero hue or saturation");

  // divider result stays within six sectors
  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && !hsv_o.hue_undefined |-> hsv_o.hue <= HueMax)
    else $error("hue beyond full circle");

  // a coloured pixel has a nonzero maximum
  a_bri_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && !hsv_o.hue_undefined |-> hsv_o.brightness != '0)
    else $error("defined hue with zero brightness");

  // the last stage only stalls behind a result that is not taken
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rdy[NS] |-> hsv_o.valid && !hsv_o.ready)
    else $error("pipeline stalled without a blocked transaction");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB to HSV pixel converter. Pixels go in as
// transactions with random gaps; each accepted pixel is converted by the bench's
// own fixed-point model and queued. Each result leaving the block is compared
// field by field with the oldest queued one, under random back-pressure.
// ----------------------------------------------------------------------------

localparam int unsigned CB    = rhc_pkg::COLOR_BITS_DEF;
localparam int unsigned HFB   = rhc_pkg::HUE_FRAC_BITS_DEF;
localparam int unsigned HUE_W = HFB + rhc_pkg::HUE_INT_BITS;

typedef struct packed {
  logic [HUE_W-1:0] hue;
  logic [CB-1:0]    saturation;
  logic [CB-1:0]    brightness;
  logic             hue_undefined;
} hsv_px_t;

class hsv_scoreboard;
  hsv_px_t     awaited_q[$];
  int unsigned errors    = 0;
  int unsigned n_pixels  = 0;
  int unsigned n_results = 0;
  int unsigned n_grey    = 0;
  int unsigned n_sector[3];

  // Fixed-point conversion of one pixel
  function hsv_px_t convert_pixel(input logic [CB-1:0] r, g, b);
    int unsigned     ri, gi, bi, hi, lo, d, base, num, full;
    int              diff;
    rhc_pkg::sector_e sec;
    hsv_px_t         res;
    ri   = 32'(r);
    gi   = 32'(g);
    bi   = 32'(b);
    full = (1 << CB) - 1;
    hi = (ri > gi) ? ri : gi;
    if (bi > hi) hi = bi;
    lo = (ri < gi) ? ri : gi;
    if (bi < lo) lo = bi;
    res.brightness = hi[CB-1:0];
    if (hi == lo) begin
      res.hue           = '0;
      res.saturation    = '0;
      res.hue_undefined = 1'b1;
      n_grey++;
      return res;
    end
    d = hi - lo;
    // tie on the minimum: red wins, then green
    if (ri == lo) begin
      sec  = rhc_pkg::SEC_RED_MIN;
      base = 3;
      diff = int'(gi) - int'(bi);
    end else if (gi == lo) begin
      sec  = rhc_pkg::SEC_GREEN_MIN;
      base = 5;
      diff = int'(bi) - int'(ri);
    end else begin
      sec  = rhc_pkg::SEC_BLUE_MIN;
      base = 1;
      diff = int'(ri) - int'(gi);
    end
    n_sector[int'(sec)]++;
    num = int'(base * d) - diff;
    res.hue           = HUE_W'((num << HFB) / d);
    res.saturation    = CB'((d * full) / hi);
    res.hue_undefined = 1'b0;
    return res;
  endfunction

  function void note_pixel(input logic [CB-1:0] r, g, b);
    awaited_q = {awaited_q, convert_pixel(r, g, b)};
    n_pixels++;
  endfunction

  function void check_result(input hsv_px_t got);
    hsv_px_t exp_px;
    n_results++;
    if (awaited_q.size() == 0) begin
      $display("%0t: result with no pixel outstanding (hue %0d sat %0d val %0d undef %0b)",
               $time, got.hue, got.saturation, got.brightness, got.hue_undefined);
      errors++;
      return;
    end
    exp_px = awaited_q.pop_front();
    if (got.hue !== exp_px.hue) begin
      $display("%0t: hue expected %0d, got %0d", $time, exp_px.hue, got.hue);
      errors++;
    end
    if (got.saturation !== exp_px.saturation) begin
      $display("%0t: saturation expected %0d, got %0d", $time, exp_px.saturation,
               got.saturation);
      errors++;
    end
    if (got.brightness !== exp_px.brightness) begin
      $display("%0t: brightness expected %0d, got %0d", $time, exp_px.brightness,
               got.brightness);
      errors++;
    end
    if (got.hue_undefined !== exp_px.hue_undefined) begin
      $display("%0t: hue_undefined expected %0b, got %0b", $time, exp_px.hue_undefined,
               got.hue_undefined);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return awaited_q.size();
  endfunction
endclass

module testbench;

  localparam int unsigned N_RANDOM = 1550;
  localparam int unsigned N_TAIL   = 250;  // final stretch without idling
  localparam int unsigned DRAIN    = 32;   // idle wait after the queue has drained

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  int   stall_left = 0;

  rhc_pix_if #(.COLOR_BITS(CB)) pix_if ();
  rhc_hsv_if #(.COLOR_BITS(CB), .HUE_FRAC_BITS(HFB)) hsv_if ();

  hsv_scoreboard sb = new();

  rgb_to_hsv_converter #(
    .COLOR_BITS   (CB),
    .HUE_FRAC_BITS(HFB)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pixel_i(pix_if),
    .hsv_o  (hsv_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Transactions on both channels, seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) sb.note_pixel(pix_if.red, pix_if.green, pix_if.blue);
      if (hsv_if.valid && hsv_if.ready)
        sb.check_result('{hue: hsv_if.hue, saturation: hsv_if.saturation,
                          brightness: hsv_if.brightness,
                          hue_undefined: hsv_if.hue_undefined});
    end
  end

  // Result side: random bursts of back-pressure while idle_on is set
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      hsv_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      hsv_if.ready <= 1'b0;
    end else begin
      hsv_if.ready <= 1'b1;
    end
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance, with valid still high.
  task automatic drive_pixel(input logic [CB-1:0] r, g, b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic random_pixel(output logic [CB-1:0] r, g, b);
    logic [CB-1:0] v, lo_v;
    int            k;
    logic [CB-1:0] corner[4];
    corner = '{8'd0, 8'd1, 8'd254, 8'd255};
    k = $urandom_range(0, 9);
    r = CB'($urandom);
    g = CB'($urandom);
    b = CB'($urandom);
    case (k)
      6: begin
        // grey
        g = r;
        b = r;
      end
      7: begin
        // two components share the minimum
        lo_v = CB'($urandom_range(0, 200));
        v    = CB'($urandom_range(lo_v + 1, 255));
        case ($urandom_range(0, 2))
          0: begin r = lo_v; g = lo_v; b = v; end
          1: begin r = v; g = lo_v; b = lo_v; end
          default: begin r = lo_v; g = v; b = lo_v; end
        endcase
      end
      8: begin
        // nearly grey
        v = CB'($urandom);
        r = (v > 253) ? CB'(v - $urandom_range(0, 2)) : CB'(v + $urandom_range(0, 2));
        g = (v > 253) ? CB'(v - $urandom_range(0, 2)) : CB'(v + $urandom_range(0, 2));
        b = v;
      end
      9: begin
        r = corner[$urandom_range(0, 3)];
        g = corner[$urandom_range(0, 3)];
        b = corner[$urandom_range(0, 3)];
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [23:0]   directed_px[$];
    logic [CB-1:0] r, g, b;
    directed_px = {
      24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h0A0AC8, 24'hC80A0A, 24'h0AC80A,
      24'h010000, 24'h000100, 24'h000001, 24'hFFFEFE, 24'hFEFFFF, 24'hFFFFFE,
      24'h010203, 24'h25C85B, 24'hFF0001, 24'hFE00FF, 24'h7F807F
    };

    rst_ni       = 1'b0;
    idle_on      = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_px[i])
      drive_pixel(directed_px[i][23:16], directed_px[i][15:8], directed_px[i][7:0]);
    // sender holds off until the pipe is empty
    wait_drained();
    @(negedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        wait_drained();
        @(negedge clk_i);
      end
      if (i == N_RANDOM - N_TAIL) idle_on = 1'b0;
      random_pixel(r, g, b);
      drive_pixel(r, g, b);
    end

    wait_drained();
    repeat (DRAIN) @(negedge clk_i);

    $display("Converted %0d pixels, %0d results: %0d grey, sectors red/green/blue min %0d/%0d/%0d.",
             sb.n_pixels, sb.n_results, sb.n_grey, sb.n_sector[0], sb.n_sector[1],
             sb.n_sector[2]);
    $display("Random gaps and back-pressure, two full drains, then an unthrottled tail.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
